// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that is checked outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/wdns_pkg.sv =====
// ---------------------------------------------------------------------------
// Wave dispersion solver package
// Shared types, constants and arithmetic helpers.
// ---------------------------------------------------------------------------
package wdns_pkg;

  localparam int unsigned MaxIterationsDefault = 32;
  localparam logic [31:0] GravityReset = 32'd164584406;
  localparam logic [31:0] DepthReset   = 32'd104857600;
  localparam logic [63:0] OneQ32       = 64'h1_0000_0000;
  localparam logic [63:0] Ln2Q32       = 64'd2977044472;
  localparam logic [63:0] ExpZeroY     = Ln2Q32 * 64'd63;
  localparam logic [63:0] KdMax        = 64'd50 << 44;
  localparam logic [63:0] CMax         = 64'hFF_FFFF_FFFF;
  localparam int unsigned TaylorTerms  = 13;

  typedef enum logic [2:0] {
    REASON_CONVERGED = 3'd0,
    REASON_LIMIT     = 3'd1,
    REASON_TINY      = 3'd2,
    REASON_INVALID   = 3'd3,
    REASON_TRIVIAL   = 3'd4
  } reason_t;

  typedef enum logic [0:0] {
    ADDR_GRAVITY = 1'b0,
    ADDR_DEPTH   = 1'b1
  } reg_addr_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_CDIV, S_CWAIT, S_K0, S_KD, S_Y, S_RED, S_TAY, S_TQ,
    S_SHIFT, S_TH, S_THWAIT, S_TT, S_S, S_KT, S_DF, S_DF2, S_DDIV, S_DWAIT,
    S_UPD, S_OUT
  } engine_state_t;

  // Classified job handed from the front end to the Newton engine.
  typedef struct packed {
    logic        trivial;
    logic [31:0] omega;
    logic [31:0] gravity;
    logic [31:0] depth;
  } job_t;

  typedef struct packed {
    logic [31:0] wavenumber;
    logic [5:0]  steps_used;
    reason_t     stop_reason;
  } result_t;

  // ceil(2^36 / i) for the Taylor term division; exact for 32-bit dividends.
  function automatic logic [35:0] taylor_recip(input logic [3:0] idx);
    logic [35:0] m;
    unique case (idx)
      4'd2:    m = 36'd34359738368;
      4'd3:    m = 36'd22906492246;
      4'd4:    m = 36'd17179869184;
      4'd5:    m = 36'd13743895348;
      4'd6:    m = 36'd11453246123;
      4'd7:    m = 36'd9817068106;
      4'd8:    m = 36'd8589934592;
      4'd9:    m = 36'd7635497416;
      4'd10:   m = 36'd6871947674;
      4'd11:   m = 36'd6247225158;
      4'd12:   m = 36'd5726623062;
      4'd13:   m = 36'd5286113596;
      default: m = '0;
    endcase
    return m;
  endfunction
endpackage

// ===== rtl/wdns_div.sv =====
// ---------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module wdns_div
  import wdns_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [95:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [95:0] quotient
);
  logic [95:0] quo;
  logic [64:0] rem;
  logic [6:0]  cnt;
  logic        run;
  logic [63:0] dvs;
  logic [64:0] trial;

  assign trial = {rem[63:0], quo[95]};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 7'd96;
        quo <= dividend;
        rem <= '0;
        dvs <= divisor;
      end else if (run) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          quo <= {quo[94:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[94:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/wdns_front.sv =====
// ---------------------------------------------------------------------------
// Solver front end
// Accepts a frequency, snapshots configuration and queues the job.
// ---------------------------------------------------------------------------
module wdns_front
  import wdns_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] omega,
  input  logic [31:0] gravity,
  input  logic [31:0] depth,
  output logic        q_valid,
  output job_t        q_job,
  input  logic        q_pop
);
  job_t job;
  logic full;
  logic accept;

  assign accept  = start && !full;
  assign q_valid = full;
  assign q_job   = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (q_pop) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job.trivial   <= (omega == 32'd0) || (gravity == 32'd0);
      job.omega     <= omega;
      job.gravity   <= gravity;
      job.depth     <= depth;
    end
  end
endmodule

// ===== rtl/wdns_engine.sv =====
// ---------------------------------------------------------------------------
// Newton engine
// Sequencer running the Newton loop; variable divisions share a serial
// divider, the exp argument is reduced by repeated subtraction and the
// Taylor terms are divided by reciprocal multiplication.
// ---------------------------------------------------------------------------
module wdns_engine
  import wdns_pkg::*;
#(
  parameter int unsigned MAX_ITERATIONS = MaxIterationsDefault
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  job_t    q_job,
  output logic    q_pop,
  output logic    busy,
  output logic    res_valid,
  output result_t res
);
  `include "assert_macros.svh"

  engine_state_t st, st_next;
  job_t j;
  logic [63:0] c, k, kd, r, term, sum, e, t, s, kt, df, mag, prod;
  logic [5:0]  n;
  logic [3:0]  ti;
  logic [6:0]  it;
  reason_t     reason;
  logic        positive;

  logic [63:0] tay_prod, tt_prod, kt_prod, delta, head;
  logic [67:0] tq_prod;
  logic [61:0] sd_prod;
  logic [31:0] tq;
  logic        upd_stop;

  logic        d_start, d_done;
  logic [95:0] d_dividend, d_quo;
  logic [63:0] d_divisor;

  wdns_div u_div (
    .clk(clk), .rst(rst), .start(d_start), .dividend(d_dividend),
    .divisor(d_divisor), .done(d_done), .quotient(d_quo)
  );

  assign tay_prod = term[31:0] * r[31:0];
  assign tq_prod  = prod[31:0] * taylor_recip(ti);
  assign tq       = (ti == 4'd1) ? prod[31:0] : tq_prod[67:36];
  assign tt_prod  = t[31:0] * t[31:0];
  assign kt_prod  = t[32] ? {k[31:0], 32'd0} : k[31:0] * t[31:0];
  assign sd_prod  = s[32] ? {kd[49:20], 32'd0} : kd[49:20] * s[31:0];
  assign delta    = d_quo[63:0];
  assign head     = 64'hFFFF_FFFF - k;
  assign upd_stop = positive ? ((delta >= k) || (delta <= 64'd1)) :
                    ((delta > head) ? (head <= 64'd1) : (delta <= 64'd1));

  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE:   if (q_valid) st_next = S_SQ;
      S_SQ:     st_next = j.trivial ? S_OUT : S_CDIV;
      S_CDIV:   st_next = S_CWAIT;
      S_CWAIT:  if (d_done) st_next = S_K0;
      S_K0:     st_next = (j.depth == 32'd0) ? S_OUT : S_KD;
      S_KD:     st_next = S_Y;
      S_Y:      st_next = S_RED;
      S_RED: begin
        priority if (r >= ExpZeroY) st_next = S_SHIFT;
        else if (r >= Ln2Q32) st_next = S_RED;
        else st_next = S_TAY;
      end
      S_TAY:    st_next = S_TQ;
      S_TQ:     st_next = (ti == 4'(TaylorTerms)) ? S_SHIFT : S_TAY;
      S_SHIFT:  st_next = S_TH;
      S_TH:     st_next = (e == 64'd0) ? S_KT : S_THWAIT;
      S_THWAIT: if (d_done) st_next = S_TT;
      S_TT:     st_next = S_S;
      S_S:      st_next = S_KT;
      S_KT:     st_next = S_DF;
      S_DF:     st_next = S_DF2;
      S_DF2:    st_next = (df == 64'd0) ? S_OUT : S_DDIV;
      S_DDIV:   st_next = S_DWAIT;
      S_DWAIT:  if (d_done) st_next = S_UPD;
      S_UPD:    st_next = (upd_stop || it >= 7'(MAX_ITERATIONS)) ? S_OUT : S_KD;
      S_OUT:    st_next = S_IDLE;
      default:  st_next = S_IDLE;
    endcase
  end

  always_comb begin
    d_start    = 1'b0;
    d_dividend = '0;
    d_divisor  = 64'd1;
    q_pop      = (st == S_IDLE) && q_valid;
    unique case (st)
      S_CDIV: begin
        d_start = 1'b1; d_dividend = {32'd0, prod}; d_divisor = {32'd0, j.gravity};
      end
      S_TH: begin
        d_start = (e != 64'd0); d_dividend = {(OneQ32 - e), 32'd0}; d_divisor = OneQ32 + e;
      end
      S_DDIV: begin
        d_start = 1'b1; d_dividend = {8'd0, mag, 24'd0}; d_divisor = df;
      end
      default: ;
    endcase
  end

  assign busy = (st != S_IDLE) || q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      st <= st_next;
      res_valid <= (st == S_OUT);
    end
  end

  always_ff @(posedge clk) begin
    unique case (st)
      S_IDLE: if (q_valid) begin
        j <= q_job; it <= '0; reason <= REASON_LIMIT;
      end
      S_SQ: prod <= j.omega * j.omega;
      S_CWAIT: if (d_done) c <= (d_quo > 96'(CMax)) ? CMax : d_quo[63:0];
      S_K0: begin
        k <= {32'd0, c[39:8]};
        if (j.depth == 32'd0) reason <= REASON_TRIVIAL;
      end
      S_KD: kd <= k[31:0] * j.depth;
      S_Y: begin
        kd <= (kd > KdMax) ? KdMax : kd;
        r <= ((kd > KdMax) ? KdMax : kd) >> 11;
        n <= '0;
        term <= OneQ32; sum <= OneQ32; ti <= 4'd1;
      end
      S_RED: begin
        priority if (r >= ExpZeroY) begin
          n <= 6'd63;
        end else if (r >= Ln2Q32) begin
          r <= r - Ln2Q32;
          n <= n + 6'd1;
        end
      end
      S_TAY: prod <= (ti == 4'd1) ? r : {32'd0, tay_prod[63:32]};
      S_TQ: begin
        term <= {32'd0, tq};
        sum <= ti[0] ? sum - {32'd0, tq} : sum + {32'd0, tq};
        ti <= ti + 4'd1;
      end
      S_SHIFT: e <= (n == 6'd63) ? 64'd0 : (sum >> n);
      S_TH: if (e == 64'd0) begin
        t <= OneQ32; s <= '0;
      end
      S_THWAIT: if (d_done) t <= d_quo[63:0];
      S_TT: prod <= {32'd0, tt_prod[63:32]};
      S_S: s <= OneQ32 - prod;
      S_KT: begin
        kt <= {24'd0, kt_prod[63:24]};
        prod <= {26'd0, sd_prod[61:24]};
      end
      S_DF: begin
        df <= t + prod;
        positive <= kt >= c;
        mag <= (kt >= c) ? kt - c : c - kt;
        it <= it + 7'd1;
      end
      S_DF2: if (df == 64'd0) reason <= REASON_TINY;
      S_UPD: begin
        if (positive) begin
          if (delta >= k) reason <= REASON_INVALID;
          else begin
            k <= k - delta;
            if (delta <= 64'd1) reason <= REASON_CONVERGED;
          end
        end else begin
          if (delta > head) begin
            if (head <= 64'd1) reason <= REASON_CONVERGED;
            k <= 64'hFFFF_FFFF;
          end else begin
            k <= k + delta;
            if (delta <= 64'd1) reason <= REASON_CONVERGED;
          end
        end
      end
      S_OUT: begin
        if (j.trivial) begin
          res.wavenumber <= '0; res.steps_used <= '0; res.stop_reason <= REASON_TRIVIAL;
        end else begin
          res.wavenumber <= k[31:0];
          res.steps_used <= (it > 7'd63) ? 6'd63 : it[5:0];
          res.stop_reason <= reason;
        end
      end
      default: ;
    endcase
  end

  `ASSERT_NEXT(a_res_one, clk, rst, res_valid, !res_valid)
  `ASSERT_IMPLY(a_idle_quiet, clk, rst, st == S_IDLE, !d_done)
  `ASSERT_IMPLY(a_pop_idle, clk, rst, q_pop, st == S_IDLE)
  `ASSERT_IMPLY(a_it_cap, clk, rst, st != S_IDLE, it <= 7'(MAX_ITERATIONS))
endmodule

// ===== rtl/wave_dispersion_newton_solver.sv =====
// ---------------------------------------------------------------------------
// Wave dispersion Newton solver
// Solves g*k*tanh(k*h) = omega^2 for k; one result strobe per accepted start.
// ---------------------------------------------------------------------------
// One transaction at a time: start is taken while busy is low, and busy stays
// high until the result has been presented. The result is presented on
// wavenumber, steps_used and stop_reason in the cycle where done is high and
// holds until the next result; the receiver cannot stall it. Write gravity
// (address 0) and depth (address 4) only while busy is low. A trivial case
// skips the divider, and the first guess is set by one serial division. Each
// Newton step then runs two serial divisions (tanh, step), the exp argument
// reduction and the Taylor series; with deep water the tanh work is skipped.
// An item runs at most MAX_ITERATIONS Newton steps (32 by default).
module wave_dispersion_newton_solver
  import wdns_pkg::*;
#(
  parameter int unsigned MAX_ITERATIONS = MaxIterationsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] angular_frequency,
  output logic        done,
  output logic [31:0] wavenumber,
  output logic [5:0]  steps_used,
  output logic [2:0]  stop_reason,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [31:0] gravity, water_depth;
  logic q_valid, q_pop, eng_busy;
  job_t q_job;
  result_t res;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= GravityReset;
      water_depth <= DepthReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == ADDR_GRAVITY) gravity <= pwdata;
      else water_depth <= pwdata;
    end
  end
  assign prdata = (paddr[2] == ADDR_DEPTH) ? water_depth : gravity;

  wdns_front u_front (
    .clk(clk), .rst(rst), .start(start && !busy), .omega(angular_frequency),
    .gravity(gravity), .depth(water_depth),
    .q_valid(q_valid), .q_job(q_job), .q_pop(q_pop)
  );

  wdns_engine #(.MAX_ITERATIONS(MAX_ITERATIONS)) u_eng (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_job(q_job), .q_pop(q_pop),
    .busy(eng_busy), .res_valid(done), .res(res)
  );

  assign busy = eng_busy || done;
  assign wavenumber  = res.wavenumber;
  assign steps_used  = res.steps_used;
  assign stop_reason = res.stop_reason;
endmodule

// ===== sim/tb_wave_dispersion_newton_solver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wave dispersion Newton solver testbench
// Drives angular frequencies through the command port under several gravity
// and depth settings, predicts wavenumber, step count and stop reason with a
// fixed-point Newton model, and checks every result strobe in order.
// ----------------------------------------------------------------------------
module tb_wave_dispersion_newton_solver;
  import wdns_pkg::*;

  localparam longint unsigned CycleLimit = 64'd60_000_000;
  localparam int unsigned     NumDirected = 9;

  typedef struct packed {
    logic [31:0] k;
    logic [5:0]  steps;
    logic [2:0]  reason;
  } solution_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] angular_frequency;
  logic        done;
  logic [31:0] wavenumber;
  logic [5:0]  steps_used;
  logic [2:0]  stop_reason;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] gravity_q;
  logic [31:0] depth_q;
  solution_t   pending_q[$];
  int unsigned mismatches;
  longint unsigned cycles;

  logic [31:0] directed_omega [NumDirected];
  logic        directed_known [NumDirected];

  wave_dispersion_newton_solver i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .angular_frequency(angular_frequency), .done(done), .wavenumber(wavenumber),
    .steps_used(steps_used), .stop_reason(stop_reason), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] exp_neg(input logic [63:0] y);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] sum;
    n = y / Ln2Q32;
    r = y - n * Ln2Q32;
    term = OneQ32;
    sum = OneQ32;
    for (int i = 1; i <= TaylorTerms; i++) begin
      term = ((term * r) >> 32) / i;
      if (i % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    if (n >= 63) return 64'd0;
    return sum >> n;
  endfunction

  function automatic solution_t solve_wavenumber(input logic [31:0] omega,
                                                 input logic [31:0] grav,
                                                 input logic [31:0] depth);
    solution_t   sol;
    logic [63:0] c, k, kd, e, t, s, kt, df, mag, delta, nxt, diff;
    logic        positive;
    logic        stopped;
    if (omega == 0 || grav == 0) begin
      sol.k = 32'd0;
      sol.steps = 6'd0;
      sol.reason = REASON_TRIVIAL;
      return sol;
    end
    c = ({32'd0, omega} * {32'd0, omega}) / {32'd0, grav};
    if (c > CMax) c = CMax;
    k = c >> 8;
    if (depth == 0) begin
      sol.k = k[31:0];
      sol.steps = 6'd0;
      sol.reason = REASON_TRIVIAL;
      return sol;
    end
    sol.steps = 6'(MaxIterationsDefault);
    sol.reason = REASON_LIMIT;
    stopped = 1'b0;
    for (int i = 0; i < MaxIterationsDefault && !stopped; i++) begin
      kd = k * {32'd0, depth};
      if (kd > KdMax) kd = KdMax;
      e = exp_neg(kd >> 11);
      if (e == 0) begin
        t = OneQ32;
        s = 64'd0;
      end else begin
        t = ((OneQ32 - e) << 32) / (OneQ32 + e);
        s = OneQ32 - ((t * t) >> 32);
      end
      kt = (k * t) >> 24;
      df = t + (((kd >> 20) * s) >> 24);
      if (df == 0) begin
        sol.reason = REASON_TINY;
        sol.steps = 6'(i + 1);
        stopped = 1'b1;
      end else begin
        positive = kt >= c;
        mag = positive ? kt - c : c - kt;
        delta = (mag << 24) / df;
        if (positive && delta >= k) begin
          sol.reason = REASON_INVALID;
          sol.steps = 6'(i + 1);
          stopped = 1'b1;
        end else begin
          if (positive) begin
            nxt = k - delta;
            diff = delta;
          end else begin
            nxt = (delta > 64'hFFFF_FFFF - k) ? 64'hFFFF_FFFF : k + delta;
            diff = nxt - k;
          end
          k = nxt;
          if (diff <= 1) begin
            sol.reason = REASON_CONVERGED;
            sol.steps = 6'(i + 1);
            stopped = 1'b1;
          end
        end
      end
    end
    sol.k = k[31:0];
    return sol;
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input reg_addr_t idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == ADDR_GRAVITY) gravity_q = value;
    else depth_q = value;
  endtask

  // Hold start until the transaction is taken; start stays high for the caller.
  task automatic send(input logic [31:0] omega, input logic known, input solution_t sol);
    start <= 1'b1;
    angular_frequency <= omega;
    do @(posedge clk); while (busy);
    pending_q.push_back(known ? sol : solve_wavenumber(omega, gravity_q, depth_q));
  endtask

  task automatic idle(input int unsigned n);
    start <= 1'b0;
    angular_frequency <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_omega();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: return $urandom_range(32'h1000_0000, 32'h4000_0000);
      default: return $urandom_range(32'h0400_0000, 32'h2000_0000);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result k=%h", wavenumber);
      end else begin
        solution_t want;
        want = pending_q.pop_front();
        if (want.k !== wavenumber || want.steps !== steps_used ||
            want.reason !== stop_reason) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected k=%h steps=%0d reason=%0d, got k=%h steps=%0d reason=%0d",
                     want.k, want.steps, want.reason, wavenumber, steps_used, stop_reason);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    solution_t     zero_sol;
    logic [31:0]   gset [7];
    logic [31:0]   dset [7];
    int unsigned   count;
    cycles = 0;
    mismatches = 0;
    rst = 1'b1;
    start = 1'b0;
    angular_frequency = 32'd0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    gravity_q = GravityReset;
    depth_q = DepthReset;
    zero_sol.k = 32'd0;
    zero_sol.steps = 6'd0;
    zero_sol.reason = REASON_TRIVIAL;

    directed_omega = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h1000_0000, 32'h2000_0000,
                       32'h3000_0000, 32'h0000_0100, 32'h8000_0000, 32'h0080_0000};
    directed_known = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    gset = '{GravityReset, 32'd0, 32'hFFFF_FFFF, GravityReset, GravityReset,
             32'd1, 32'h0100_0000};
    dset = '{DepthReset, DepthReset, 32'hFFFF_FFFF, 32'd0, 32'd1,
             32'h0010_0000, 32'h0000_8000};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NumDirected; i++)
      send(directed_omega[i], directed_known[i], zero_sol);
    idle(1);

    count = 0;
    for (int p = 0; p < 7; p++) begin
      wait_drained();
      write_reg(ADDR_GRAVITY, gset[p]);
      write_reg(ADDR_DEPTH, dset[p]);
      for (int j = 0; j < 42; j++) begin
        if (count == 150) begin
          idle(1);
          wait_drained();
        end
        if (!(count >= 60 && count < 110) && $urandom_range(0, 99) < 13)
          idle($urandom_range(1, 5));
        send(rand_omega(), 1'b0, zero_sol);
        count++;
      end
      idle(1);
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
